// File: design/hcfs_pkg.sv
// hcfs_pkg: shared constants, status codes and the job record for the frame synchroniser
// no dependencies; imported by every design file and by the checker
`timescale 1ns / 1ps

package hcfs_pkg;

    // search window and title
    localparam int WINDOW_BYTES = 10;
    localparam int TITLE_LEN    = 9;
    localparam int WIN_IDX_W    = $clog2(WINDOW_BYTES);

    // default frame buffer size, low bits of length carried on the output
    localparam int BUFFER_BYTES_DEF = 1024;
    localparam int LEN_OUT_W        = 11;

    // jobs held between front and back
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // "$initsess"
    localparam logic [7:0] TITLE_BYTES [TITLE_LEN] = '{
        8'h24, 8'h69, 8'h6E, 8'h69, 8'h74, 8'h73, 8'h65, 8'h73, 8'h73
    };

    // result status codes
    localparam logic [1:0] ST_BYTE = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_DROP = 2'd2;

    // one job: a whole title window, or a single body byte in the low byte of win
    typedef struct packed {
        logic                        is_title;
        logic [1:0]                  status;
        logic [WINDOW_BYTES*8-1:0]   win;
    } t_job;

endpackage

// File: design/hcfs_front.sv
// hcfs_front: search window, title match, frame tracking and CR LF / overflow classification
// depends on hcfs_pkg
`timescale 1ns / 1ps

module hcfs_front #(
    parameter int BUFFER_BYTES = hcfs_pkg::BUFFER_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    output logic          o_push,
    output hcfs_pkg::t_job o_job
);
    import hcfs_pkg::*;

    localparam int LEN_W = $clog2(BUFFER_BYTES);
    localparam logic [LEN_W:0] DROP_LEN = (LEN_W + 1)'(BUFFER_BYTES - 1);

    logic                      r_in_frame, n_in_frame;
    logic [WINDOW_BYTES*8-1:0] r_win, n_win;
    logic [WIN_IDX_W-1:0]      r_cnt, n_cnt;
    logic [LEN_W-1:0]          r_len, n_len;
    logic [7:0]                r_prior, n_prior;

    logic [WINDOW_BYTES*8-1:0] win_ins;
    logic [LEN_W:0]            len_inc;
    logic                      title_hit;
    logic                      dollar_found;
    logic [WIN_IDX_W-1:0]      shift;

    always_comb begin
        n_in_frame = r_in_frame;
        n_win      = r_win;
        n_cnt      = r_cnt;
        n_len      = r_len;
        n_prior    = r_prior;
        o_push     = 1'b0;
        o_job      = '0;

        win_ins = r_win;
        win_ins[{r_cnt, 3'b000} +: 8] = i_data_byte;
        len_inc = {1'b0, r_len} + 1'b1;

        title_hit = 1'b1;
        for (int k = 0; k < TITLE_LEN; k++) begin
            if (win_ins[k*8 +: 8] != TITLE_BYTES[k]) begin
                title_hit = 1'b0;
            end
        end

        // lowest '$' at position one or later
        dollar_found = 1'b0;
        shift        = '0;
        for (int k = WINDOW_BYTES - 1; k >= 1; k--) begin
            if (win_ins[k*8 +: 8] == CH_DOLLAR) begin
                dollar_found = 1'b1;
                shift        = WIN_IDX_W'(k);
            end
        end

        if (i_accept) begin
            if (r_in_frame) begin
                o_push         = 1'b1;
                o_job.is_title = 1'b0;
                o_job.win[7:0] = i_data_byte;
                n_len          = len_inc[LEN_W-1:0];
                n_prior        = i_data_byte;
                if (len_inc >= DROP_LEN) begin
                    o_job.status = ST_DROP;
                    n_in_frame   = 1'b0;
                    n_cnt        = '0;
                end else if (i_data_byte == CH_LF && r_prior == CH_CR) begin
                    o_job.status = ST_DONE;
                    n_in_frame   = 1'b0;
                    n_cnt        = '0;
                end else begin
                    o_job.status = ST_BYTE;
                end
            end else if (r_cnt != WIN_IDX_W'(WINDOW_BYTES - 1)) begin
                n_win = win_ins;
                n_cnt = r_cnt + 1'b1;
            end else if (title_hit) begin
                // title plus one body byte; that byte cannot close or overflow the frame
                o_push         = 1'b1;
                o_job.is_title = 1'b1;
                o_job.status   = ST_BYTE;
                o_job.win      = win_ins;
                n_in_frame     = 1'b1;
                n_cnt          = '0;
                n_len          = LEN_W'(WINDOW_BYTES);
                n_prior        = win_ins[(WINDOW_BYTES-1)*8 +: 8];
            end else if (dollar_found) begin
                n_win = win_ins >> {shift, 3'b000};
                n_cnt = WIN_IDX_W'(WINDOW_BYTES - 1) - shift + WIN_IDX_W'(1);
            end else begin
                n_win = win_ins;
                n_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_cnt      <= '0;
            r_len      <= '0;
            r_prior    <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_cnt      <= n_cnt;
            r_len      <= n_len;
            r_prior    <= n_prior;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

endmodule

// File: design/hcfs_queue.sv
// hcfs_queue: small job queue between front and back
// depends on hcfs_pkg
`timescale 1ns / 1ps

module hcfs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hcfs_pkg::t_job i_job,
    input  logic           i_pop,
    output hcfs_pkg::t_job o_head,
    output logic           o_full,
    output logic           o_empty
);
    import hcfs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_count;

    assign o_head  = r_mem[r_rd];
    assign o_full  = (r_count == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// File: design/hcfs_back.sv
// hcfs_back: expands jobs into frame bytes with running length and checksum
// depends on hcfs_pkg
`timescale 1ns / 1ps

module hcfs_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hcfs_pkg::t_job                 i_head,
    input  logic                           i_empty,
    output logic                           o_pop,
    input  logic                           i_stall,
    output logic                           o_valid,
    output logic [7:0]                     o_frame_byte,
    output logic [1:0]                     o_status,
    output logic                           o_is_last,
    output logic [7:0]                     o_frame_checksum,
    output logic [hcfs_pkg::LEN_OUT_W-1:0] o_frame_length
);
    import hcfs_pkg::*;

    logic                 r_valid;
    logic [WIN_IDX_W-1:0] r_idx, n_idx;
    logic [7:0]           r_byte, r_xor;
    logic [1:0]           r_status;
    logic                 r_last;
    logic [LEN_OUT_W-1:0] r_len;

    logic                 load, take, first, last;
    logic [7:0]           byte_sel, xor_nx;
    logic [LEN_OUT_W-1:0] len_nx;

    always_comb begin
        load     = !r_valid || !i_stall;
        take     = load && !i_empty;
        byte_sel = i_head.is_title ? i_head.win[{r_idx, 3'b000} +: 8] : i_head.win[7:0];
        first    = i_head.is_title && (r_idx == '0);
        last     = !i_head.is_title || (r_idx == WIN_IDX_W'(WINDOW_BYTES - 1));
        len_nx   = (first ? '0 : r_len) + 1'b1;
        xor_nx   = (first ? 8'h00 : r_xor) ^ byte_sel;
        o_pop    = take && last;
        n_idx    = r_idx;
        if (take) begin
            n_idx = last ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= take;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte   <= byte_sel;
            r_status <= i_head.is_title ? ST_BYTE : i_head.status;
            r_last   <= last;
            r_len    <= len_nx;
            r_xor    <= xor_nx;
        end
    end

    assign o_valid          = r_valid;
    assign o_frame_byte     = r_byte;
    assign o_status         = r_status;
    assign o_is_last        = r_last;
    assign o_frame_checksum = r_xor;
    assign o_frame_length   = r_len;

endmodule

// File: design/header_crlf_frame_sync_top.sv
// header_crlf_frame_sync_top: byte-stream frame synchroniser, front / queue / back
// depends on hcfs_pkg, hcfs_front, hcfs_queue, hcfs_back
`timescale 1ns / 1ps

// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_data_byte
// output    out        o_valid / i_stall   o_frame_byte, o_status, o_is_last,
//                                          o_frame_checksum, o_frame_length
//
// one byte is taken every cycle while the job queue has room
// a title match turns into ten output transfers, one per cycle from the back end while i_stall is low;
// the four-job queue soaks these bursts up and o_stall rises only when it is full
// body bytes give one transfer each; an accepted byte's job passes through the queue
// and then the back-end output register before o_valid rises for it
// synchronous active-low reset empties window and queue; no clearing pass is needed
// a stalled output holds its register; the front keeps taking bytes until the queue fills

module header_crlf_frame_sync_top #(
    parameter int BUFFER_BYTES = hcfs_pkg::BUFFER_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_data_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_frame_byte,
    output logic [1:0]                     o_status,
    output logic                           o_is_last,
    output logic [7:0]                     o_frame_checksum,
    output logic [hcfs_pkg::LEN_OUT_W-1:0] o_frame_length
);
    import hcfs_pkg::*;

    logic accept;
    logic q_push, q_pop, q_full, q_empty;
    t_job q_job, q_head;

    // a byte is taken whenever the queue can hold the job it might raise
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    // front: window search, title match, end-of-frame and overflow decisions
    hcfs_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_push      (q_push),
        .o_job       (q_job)
    );

    // decoupling queue of classified jobs
    hcfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: one output transfer per cycle while the output is not stalled, running checksum and length
    hcfs_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (q_head),
        .i_empty          (q_empty),
        .o_pop            (q_pop),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_frame_byte     (o_frame_byte),
        .o_status         (o_status),
        .o_is_last        (o_is_last),
        .o_frame_checksum (o_frame_checksum),
        .o_frame_length   (o_frame_length)
    );

endmodule

// File: design/hcfs_checker.sv
// hcfs_checker: port-level checks on the frame synchroniser, bound to the top level
// depends on hcfs_pkg and header_crlf_frame_sync_top
`timescale 1ns / 1ps

module hcfs_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic [7:0]                     i_data_byte,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [7:0]                     o_frame_byte,
    input logic [1:0]                     o_status,
    input logic                           o_is_last,
    input logic [7:0]                     o_frame_checksum,
    input logic [hcfs_pkg::LEN_OUT_W-1:0] o_frame_length
);
    import hcfs_pkg::*;

    // nothing is offered straight after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a stalled input transfer keeps its byte
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data_byte))
        else $error("stalled input changed");

    // a stalled transfer keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_byte) && $stable(o_status)
            && $stable(o_frame_checksum) && $stable(o_frame_length))
        else $error("stalled output changed");

    // frame end or drop is always the last result of its byte
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_DONE || o_status == ST_DROP) |-> o_is_last)
        else $error("frame end not marked last");

    // unused status code never shows
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_BYTE || o_status == ST_DONE || o_status == ST_DROP))
        else $error("bad status code");

endmodule

bind header_crlf_frame_sync_top hcfs_checker u_hcfs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .i_data_byte      (i_data_byte),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_frame_byte     (o_frame_byte),
    .o_status         (o_status),
    .o_is_last        (o_is_last),
    .o_frame_checksum (o_frame_checksum),
    .o_frame_length   (o_frame_length)
);

// File: verif/header_crlf_frame_sync_top_test.sv
// header_crlf_frame_sync_top_test: self-checking bench for the byte-stream frame synchroniser
// drives byte transfers with random gaps and output stalls, and predicts every result in-bench
// depends on hcfs_pkg and header_crlf_frame_sync_top
`timescale 1ns / 1ps

module header_crlf_frame_sync_top_test;
    import hcfs_pkg::*;

    localparam int FRAME_BUF     = BUFFER_BYTES_DEF;
    localparam int RANDOM_ITEMS  = 200;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RESET_CYCLES  = 5;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    // one output transfer as the bench expects it
    typedef struct packed {
        logic [7:0]           fbyte;
        logic [1:0]           status;
        logic                 is_last;
        logic [7:0]           chk;
        logic [LEN_OUT_W-1:0] len;
    } t_frame_rec;

    // directed stimulus: a byte, and where obvious the single result it must give
    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        logic       has_out;
        t_frame_rec typed_rec;
    } t_script_row;

    localparam t_frame_rec NO_RESULT = '0;

    // rows marked typed carry their own expectation; the rest go through the predictor
    localparam t_script_row SCRIPT [24] = '{
        // window filling from reset with the byte extremes in front, nothing comes out
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, 1'b0, NO_RESULT},
        '{8'h24, 1'b1, 1'b0, NO_RESULT},
        '{8'h69, 1'b1, 1'b0, NO_RESULT},
        '{8'h6E, 1'b1, 1'b0, NO_RESULT},
        '{8'h69, 1'b1, 1'b0, NO_RESULT},
        '{8'h74, 1'b1, 1'b0, NO_RESULT},
        '{8'h73, 1'b1, 1'b0, NO_RESULT},
        '{8'h65, 1'b1, 1'b0, NO_RESULT},
        // full window without title: slides to the dollar at offset two
        '{8'h73, 1'b1, 1'b0, NO_RESULT},
        '{8'h73, 1'b1, 1'b0, NO_RESULT},
        // window now opens with the title: burst of ten, predicted
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        // cr lf closes the frame; title xor is 28, so the sums are easy to read
        '{CH_CR, 1'b1, 1'b1, '{CH_CR, ST_BYTE, 1'b1, 8'hDA, 11'd11}},
        '{CH_LF, 1'b1, 1'b1, '{CH_LF, ST_DONE, 1'b1, 8'hD0, 11'd12}},
        // window with a dollar only at the front: cleared outright
        '{8'h24, 1'b1, 1'b0, NO_RESULT},
        '{8'h0A, 1'b1, 1'b0, NO_RESULT},
        '{8'h0D, 1'b1, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, 1'b0, NO_RESULT},
        '{8'h55, 1'b1, 1'b0, NO_RESULT},
        '{8'hAA, 1'b1, 1'b0, NO_RESULT},
        '{8'h69, 1'b1, 1'b0, NO_RESULT},
        '{8'h73, 1'b1, 1'b0, NO_RESULT},
        '{8'h0D, 1'b1, 1'b0, NO_RESULT}
    };

    // dut connections, all inputs known from time zero
    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic [7:0]           i_data_byte = 8'h00;
    logic                 i_stall     = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [7:0]           o_frame_byte;
    logic [1:0]           o_status;
    logic                 o_is_last;
    logic [7:0]           o_frame_checksum;
    logic [LEN_OUT_W-1:0] o_frame_length;

    // predictor state, mirrors the block after reset
    logic       in_body   = 1'b0;
    logic [7:0] hunt_win [WINDOW_BYTES] = '{default: 8'h00};
    int         hunt_fill = 0;
    int         frame_len = 0;
    logic [7:0] frame_xor = 8'h00;
    logic [7:0] prev_byte = 8'h00;

    // results of the byte just predicted, and those still owed by the dut
    t_frame_rec step_out [$];
    t_frame_rec frame_bytes_due [$];
    logic [7:0] byte_plan [$];

    // quiet stretches: no sender gaps and no output stalls
    bit calm = 1'b0;

    int fail_count    = 0;
    int bytes_sent    = 0;
    int results_seen  = 0;
    int random_sent   = 0;
    int titles_found  = 0;
    int frames_closed = 0;
    int frames_dropped = 0;

    header_crlf_frame_sync_top #(
        .BUFFER_BYTES(FRAME_BUF)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_frame_byte    (o_frame_byte),
        .o_status        (o_status),
        .o_is_last       (o_is_last),
        .o_frame_checksum(o_frame_checksum),
        .o_frame_length  (o_frame_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void emit(logic [7:0] b, logic [1:0] st);
        t_frame_rec r;
        r.fbyte   = b;
        r.status  = st;
        r.is_last = 1'b0;
        r.chk     = frame_xor;
        r.len     = LEN_OUT_W'(frame_len);
        step_out.push_back(r);
    endfunction

    // a byte inside the frame body: overflow wins over cr lf
    function automatic void take_body(logic [7:0] b);
        frame_len++;
        frame_xor ^= b;
        if (frame_len >= FRAME_BUF - 1) begin
            emit(b, ST_DROP);
            in_body   = 1'b0;
            hunt_fill = 0;
            frames_dropped++;
        end else if (b == CH_LF && prev_byte == CH_CR) begin
            emit(b, ST_DONE);
            in_body   = 1'b0;
            hunt_fill = 0;
            frames_closed++;
        end else begin
            emit(b, ST_BYTE);
        end
        prev_byte = b;
    endfunction

    // a byte while hunting for the title
    function automatic void take_search(logic [7:0] b);
        logic [7:0] snap [WINDOW_BYTES];
        bit         titled;
        int         pos;
        int         i;
        if (hunt_fill >= WINDOW_BYTES)
            hunt_fill = 0;
        hunt_win[hunt_fill] = b;
        hunt_fill++;
        if (hunt_fill == WINDOW_BYTES) begin
            titled = 1'b1;
            for (i = 0; i < TITLE_LEN; i++)
                if (hunt_win[i] != TITLE_BYTES[i])
                    titled = 1'b0;
            if (titled) begin
                // title bytes go out first, then the rest of the window as body
                snap      = hunt_win;
                hunt_fill = 0;
                in_body   = 1'b1;
                frame_len = 0;
                frame_xor = 8'h00;
                titles_found++;
                for (i = 0; i < TITLE_LEN; i++) begin
                    frame_len++;
                    frame_xor ^= snap[i];
                    emit(snap[i], ST_BYTE);
                    prev_byte = snap[i];
                end
                for (i = TITLE_LEN; i < WINDOW_BYTES; i++) begin
                    if (in_body) begin
                        take_body(snap[i]);
                    end else if (hunt_fill < WINDOW_BYTES) begin
                        hunt_win[hunt_fill] = snap[i];
                        hunt_fill++;
                    end
                end
            end else begin
                // slide to the first dollar past the front, or drop the lot
                pos = WINDOW_BYTES;
                for (i = WINDOW_BYTES - 1; i >= 1; i--)
                    if (hunt_win[i] == CH_DOLLAR)
                        pos = i;
                if (pos < WINDOW_BYTES) begin
                    for (i = 0; i < WINDOW_BYTES - pos; i++)
                        hunt_win[i] = hunt_win[i + pos];
                    hunt_fill = WINDOW_BYTES - pos;
                end else begin
                    hunt_fill = 0;
                end
            end
        end
    endfunction

    // fills step_out with every result that one accepted byte causes
    function automatic void sync_predict_byte(logic [7:0] b);
        t_frame_rec r;
        step_out.delete();
        if (in_body)
            take_body(b);
        else
            take_search(b);
        if (step_out.size() > 0) begin
            r = step_out.pop_back();
            r.is_last = 1'b1;
            step_out.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // mostly no gap, some short ones, now and then a long one
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 97)
            return $urandom_range(3, 6);
        else
            return $urandom_range(10, 30);
    endfunction

    // random byte leaning towards the characters the block reacts to
    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(0, 15);
        if (r < 3)
            return CH_DOLLAR;
        else if (r == 3)
            return CH_CR;
        else if (r == 4)
            return CH_LF;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic void plan_title();
        int i;
        for (i = 0; i < TITLE_LEN; i++)
            byte_plan.push_back(TITLE_BYTES[i]);
    endfunction

    // one input transfer; typed rows replace the predicted results with their own
    task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input logic has_out = 1'b0,
                             input t_frame_rec typed_rec = NO_RESULT);
        int gap;
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        gap = calm ? 0 : idle_span();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        // transfer taken at this edge
        sync_predict_byte(b);
        bytes_sent++;
        if (!typed) begin
            foreach (step_out[k])
                frame_bytes_due.push_back(step_out[k]);
        end else if (has_out) begin
            frame_bytes_due.push_back(typed_rec);
        end
    endtask

    task automatic send_plan();
        foreach (byte_plan[k])
            send_byte(byte_plan[k]);
    endtask

    // ---------------------------------------------------------------- output side

    // random stall bursts on the result channel, none during quiet stretches
    initial begin
        int n;
        forever begin
            n = calm ? 0 : idle_span();
            repeat (n) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
            n = $urandom_range(1, 8);
            repeat (n) begin
                @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // every accepted result against the oldest one owed
    initial begin
        t_frame_rec due;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (frame_bytes_due.size() == 0) begin
                    $error("result with nothing due: frame_byte %02h status %0d",
                           o_frame_byte, o_status);
                    fail_count++;
                end else begin
                    due = frame_bytes_due.pop_front();
                    check_field("frame_byte", 16'(due.fbyte), 16'(o_frame_byte));
                    check_field("status", 16'(due.status), 16'(o_status));
                    check_field("is_last", 16'(due.is_last), 16'(o_is_last));
                    check_field("frame_checksum", 16'(due.chk), 16'(o_frame_checksum));
                    check_field("frame_length", 16'(due.len), 16'(o_frame_length));
                    results_seen++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        int         kind;
        int         span;
        int         cut;
        int         spot;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        foreach (SCRIPT[r])
            send_byte(SCRIPT[r].data, SCRIPT[r].typed, SCRIPT[r].has_out,
                      SCRIPT[r].typed_rec);

        // random part: mostly proper frames with random bodies, mixed with broken titles and noise
        while (random_sent < RANDOM_ITEMS) begin
            byte_plan.delete();
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                repeat ($urandom_range(0, 4))
                    byte_plan.push_back(noise_byte());
                plan_title();
                span = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 90)
                                                   : $urandom_range(0, 24);
                repeat (span)
                    byte_plan.push_back(noise_byte());
                byte_plan.push_back(CH_CR);
                byte_plan.push_back(CH_LF);
            end else if (kind < 80) begin
                // title cut short or left whole, sometimes with one byte spoilt
                plan_title();
                cut = $urandom_range(1, TITLE_LEN);
                while (byte_plan.size() > cut)
                    void'(byte_plan.pop_back());
                if ($urandom_range(0, 1) == 1) begin
                    spot = $urandom_range(0, cut - 1);
                    byte_plan[spot] = byte_plan[spot] ^ 8'($urandom_range(1, 255));
                end
                repeat ($urandom_range(0, 6))
                    byte_plan.push_back(noise_byte());
            end else begin
                repeat ($urandom_range(1, 12))
                    byte_plan.push_back(noise_byte());
            end
            random_sent += byte_plan.size();
            send_plan();
        end

        @(negedge i_clk);
        i_valid <= 1'b0;

        // let the queue empty, then watch a little longer for stray results
        while (frame_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d input bytes and %0d checked results", bytes_sent,
                 results_seen);
        $display("titles found %0d, frames closed by cr lf %0d, frames dropped at limit %0d",
                 titles_found, frames_closed, frames_dropped);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule

// File: header_crlf_frame_sync_top.f
design/hcfs_pkg.sv
design/hcfs_front.sv
design/hcfs_queue.sv
design/hcfs_back.sv
design/header_crlf_frame_sync_top.sv
design/hcfs_checker.sv
verif/header_crlf_frame_sync_top_test.sv
